// ===== hw/rtl/pdld_pkg.sv =====
package pdld_pkg;

   localparam int CFG_W = 16;
   localparam int CAP_PORT_W = 16;
   localparam int CAPTURE_BITS_DEFAULT = 16;
   localparam int LEVEL_W = 7;
   localparam int QUOT_W = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [LEVEL_W-1:0] DUTY_FULL = 7'd100;
   localparam logic [LEVEL_W-1:0] DUTY_ZERO = 7'd0;
   localparam logic [LEVEL_W-1:0] DUTY_STEP_MIN = 7'd3;
   localparam logic [LEVEL_W-1:0] MUL_SCALE = 7'd100;

   localparam logic [1:0] OP_PERIOD = 2'd0;
   localparam logic [1:0] OP_WIDTH = 2'd1;
   localparam logic [1:0] OP_PIN = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_NOMINAL_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD_TOLERANCE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STARTUP_SKIP = 2'd2;

   localparam logic [CFG_W-1:0] NOMINAL_PERIOD_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] PERIOD_TOLERANCE_RESET = 16'd50;
   localparam logic [CFG_W-1:0] STARTUP_SKIP_RESET = 16'd1000;

   // floor(-50.9 + 32.8 * ln d), clamped to 0
   localparam logic [LEVEL_W-1:0] LEVEL_TABLE [0:100] = '{
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd7,  7'd12, 7'd17, 7'd21,
      7'd24, 7'd27, 7'd30, 7'd33, 7'd35, 7'd37, 7'd40, 7'd42, 7'd43, 7'd45,
      7'd47, 7'd48, 7'd50, 7'd51, 7'd53, 7'd54, 7'd55, 7'd57, 7'd58, 7'd59,
      7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69,
      7'd70, 7'd70, 7'd71, 7'd72, 7'd73, 7'd73, 7'd74, 7'd75, 7'd76, 7'd76,
      7'd77, 7'd78, 7'd78, 7'd79, 7'd79, 7'd80, 7'd81, 7'd81, 7'd82, 7'd82,
      7'd83, 7'd83, 7'd84, 7'd84, 7'd85, 7'd86, 7'd86, 7'd87, 7'd87, 7'd87,
      7'd88, 7'd88, 7'd89, 7'd89, 7'd90, 7'd90, 7'd91, 7'd91, 7'd92, 7'd92,
      7'd92, 7'd93, 7'd93, 7'd94, 7'd94, 7'd94, 7'd95, 7'd95, 7'd95, 7'd96,
      7'd96, 7'd97, 7'd97, 7'd97, 7'd98, 7'd98, 7'd98, 7'd99, 7'd99, 7'd99,
      7'd100
   };

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/pwm_duty_level_decoder_core.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_opcode, req_capture_value, req_pin_high
// rsp     | out       | rsp_valid/rsp_ready | rsp_level
// csr     | in        | csr_write_en        | csr_index, csr_wdata
//
// A period capture in the window steps through accept, tolerance check, multiply,
// divider start, seven divider steps, divider done, then the apply step. A pulse at
// least as wide as the period skips the divider; a rejected period stops at the check.
// Pin ticks go to apply; width captures, zero periods and unused opcodes end at accept.
// req_ready is low while an item is in work; one result may wait in the output
// register while the next item is accepted, and the apply step holds until it drains.
// Synchronous active-high reset; no clearing pass.
module pwm_duty_level_decoder_core #(
   parameter int CAPTURE_BITS = pdld_pkg::CAPTURE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [pdld_pkg::CAP_PORT_W-1:0]     req_capture_value,
   input  logic                                req_pin_high,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pdld_pkg::LEVEL_W-1:0]        rsp_level,
   input  logic                                csr_write_en,
   input  logic [pdld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pdld_pkg::CFG_W-1:0]          csr_wdata
);
   import pdld_pkg::*;

   localparam int CAP_W = (CAPTURE_BITS < CAP_PORT_W) ? CAPTURE_BITS : CAP_PORT_W;
   localparam int NUM_W = CAP_W + QUOT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CFG_W-1:0]   nominal_ff, nominal_in;
   logic [CFG_W-1:0]   tolerance_ff, tolerance_in;
   logic [CFG_W-1:0]   skip_ff, skip_in;
   logic [CFG_W-1:0]   skipped_ff, skipped_in;
   logic [CAP_W-1:0]   width_ff, width_in;
   logic [CAP_W-1:0]   period_ff, period_in;
   logic [NUM_W-1:0]   numer_ff, numer_in;
   logic [LEVEL_W-1:0] duty_ff, duty_in;
   logic [LEVEL_W-1:0] last_ff, last_in;
   logic               have_value_ff, have_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               div_start;
   div_status_type     div_status;
   logic [QUOT_W-1:0]  div_quot;

   logic               req_xfer;
   logic [CAP_W-1:0]   cap_in;
   logic [CFG_W-1:0]   period_ext;
   logic [CFG_W-1:0]   period_dist;
   logic               endpoint;
   logic               first_or_edge;
   logic [LEVEL_W-1:0] step;
   logic               emit;
   logic               out_free;

   pdld_div #(
      .CAP_W(CAP_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer_ff),
      .denom (period_ff),
      .status(div_status),
      .quot  (div_quot)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign cap_in      = req_capture_value[CAP_W-1:0];
   assign period_ext  = CFG_W'(period_ff);
   assign period_dist = (period_ext > nominal_ff) ? (period_ext - nominal_ff)
                                                  : (nominal_ff - period_ext);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign endpoint      = (duty_ff == DUTY_ZERO) || (duty_ff == DUTY_FULL);
   assign first_or_edge = !have_value_ff || (endpoint && (last_ff != duty_ff));
   assign step          = (last_ff > duty_ff) ? (last_ff - duty_ff) : (duty_ff - last_ff);
   assign emit          = first_or_edge || (step > DUTY_STEP_MIN);

   always_comb begin
      nominal_in   = nominal_ff;
      tolerance_in = tolerance_ff;
      skip_in      = skip_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_NOMINAL_PERIOD:   nominal_in   = csr_wdata;
            REG_PERIOD_TOLERANCE: tolerance_in = csr_wdata;
            REG_STARTUP_SKIP:     skip_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      period_in     = period_ff;
      numer_in      = numer_ff;
      duty_in       = duty_ff;
      last_in       = last_ff;
      have_value_in = have_value_ff;
      skipped_in    = skipped_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_opcode)
                  OP_WIDTH: width_in = cap_in;
                  OP_PIN: begin
                     duty_in  = req_pin_high ? DUTY_FULL : DUTY_ZERO;
                     state_in = S_APPLY;
                  end
                  OP_PERIOD: begin
                     period_in = cap_in;
                     if (cap_in != '0) begin
                        state_in = S_CHECK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            state_in = (period_dist < tolerance_ff) ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            numer_in = NUM_W'(width_ff) * NUM_W'(MUL_SCALE);
            if (width_ff >= period_ff) begin
               duty_in  = DUTY_FULL;
               state_in = S_APPLY;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // start the divider in the cycle after numer_ff is loaded
            if (!div_status.busy && !div_status.done) begin
               div_start = 1'b1;
            end
            if (div_status.done) begin
               duty_in  = div_quot;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (skipped_ff < skip_ff) begin
               skipped_in = skipped_ff + 1'b1;
               state_in   = S_IDLE;
            end else if (!emit) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_level_in  = endpoint ? duty_ff : LEVEL_TABLE[duty_ff];
               last_in       = duty_ff;
               have_value_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nominal_ff    <= NOMINAL_PERIOD_RESET;
         tolerance_ff  <= PERIOD_TOLERANCE_RESET;
         skip_ff       <= STARTUP_SKIP_RESET;
         skipped_ff    <= '0;
         width_ff      <= '0;
         last_ff       <= '0;
         have_value_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nominal_ff    <= nominal_in;
         tolerance_ff  <= tolerance_in;
         skip_ff       <= skip_in;
         skipped_ff    <= skipped_in;
         width_ff      <= width_in;
         last_ff       <= last_in;
         have_value_ff <= have_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      period_ff    <= period_in;
      numer_ff     <= numer_in;
      duty_ff      <= duty_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

`ifndef NO_ASSERTIONS
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= DUTY_FULL))
      else $error("result level above full scale");
   a_result_marks_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> have_value_ff)
      else $error("result sent before first value recorded");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide step");
   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (duty_ff <= DUTY_FULL))
      else $error("duty above full scale at apply");
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ready)
      else $error("request accepted during division");
`endif

endmodule

// ===== hw/rtl/pdld_div.sv =====
module pdld_div #(
   parameter int CAP_W = pdld_pkg::CAPTURE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [CAP_W+pdld_pkg::QUOT_W-1:0]   numer,
   input  logic [CAP_W-1:0]                    denom,
   output pdld_pkg::div_status_type            status,
   output logic [pdld_pkg::QUOT_W-1:0]         quot
);
   import pdld_pkg::*;

   localparam int NUM_W = CAP_W + QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // restoring division, one quotient bit per cycle; numer < 2^QUOT_W * denom
   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dsh_in  = {denom, {(QUOT_W-1){1'b0}}, 1'b0} >> 1;
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

`ifndef NO_ASSERTIONS
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_count_zero_at_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> (done_ff && !busy_ff))
      else $error("divider did not finish on last step");
`endif

endmodule
